FILE: rtl/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the PD line-follower steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_THR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CORR_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED = 3'd6;

  // Register widths
  localparam int unsigned THR_W   = 12;
  localparam int unsigned GAIN_W  = 10;
  localparam int unsigned LOST_W  = 8;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned SPEED_W = 8;

  // Datapath widths
  localparam int unsigned ERR_W   = 9;
  localparam int unsigned DIFF_W  = 10;
  localparam int unsigned PPROD_W = 20;
  localparam int unsigned CORR_W  = 21;
  localparam int unsigned STEER_W = 8;
  localparam int unsigned PROD_W  = SPEED_W + CORR_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

  localparam logic [STEER_W-2:0] STEER_MAG_MAX = 7'd127;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture input transaction
    logic err;       // error and gain products
    logic sum;       // PD sum
    logic mul;       // speed times |correction|, divider set-up
    logic div_step;  // one restoring division step
    logic finish;    // load the output register
  } lfpd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic in_follow;  // follow_mode of the transaction on the input port
    logic out_free;   // output register can take a new result this cycle
  } lfpd_status_t;

endpackage

FILE: rtl/lfpd_ctrl.sv
// ----------------------------------------------------------------------------
// lfpd_ctrl
// Sequencer for the PD steering datapath: capture, products, sum, multiply,
// serial division and hand-over to the output register.
// ----------------------------------------------------------------------------
module lfpd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  lfpd_pkg::lfpd_status_t status_i,
  output lfpd_pkg::lfpd_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ERR  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [lfpd_pkg::DIV_CNT_W-1:0] CntLast =
    lfpd_pkg::DIV_CNT_W'(lfpd_pkg::PROD_W - 1);

  logic [2:0]                      state_q, state_d;
  logic [lfpd_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_follow ? ST_ERR : ST_DONE;
        end
      end
      ST_ERR: begin
        cmd_o.err = 1'b1;
        state_d   = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CntLast) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted transaction did not leave idle");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> status_i.out_free)
    else $error("result loaded while output register occupied");

  a_div_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |=> (state_q == ST_DIV && cnt_q == '0))
    else $error("division did not start from step zero");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && cnt_q == CntLast) |=> (state_q == ST_DONE))
    else $error("division ran past its last step");

endmodule

FILE: rtl/lfpd_dp.sv
// ----------------------------------------------------------------------------
// lfpd_dp
// Datapath: configuration registers, error decision, PD products and sum,
// steer product, restoring divider and the output register.
// ----------------------------------------------------------------------------
module lfpd_dp #(
  parameter int unsigned SENSOR_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input payload
  input  logic                                 follow_mode_i,
  input  logic [SENSOR_BITS-1:0]               left_level_i,
  input  logic [SENSOR_BITS-1:0]               right_level_i,
  // output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lfpd_pkg::SPEED_W-1:0]         speed_out_o,
  output logic signed [lfpd_pkg::STEER_W-1:0]  steer_out_o,
  output logic signed [lfpd_pkg::CORR_W-1:0]   correction_out_o,
  // control
  input  lfpd_pkg::lfpd_cmd_t                  cmd_i,
  output lfpd_pkg::lfpd_status_t               status_o
);

  // thresholds are only compared in their low SENSOR_BITS bits
  localparam int unsigned ThrBits =
    (SENSOR_BITS < lfpd_pkg::THR_W) ? SENSOR_BITS : lfpd_pkg::THR_W;

  localparam int unsigned ErrW   = lfpd_pkg::ERR_W;
  localparam int unsigned DiffW  = lfpd_pkg::DIFF_W;
  localparam int unsigned CorrW  = lfpd_pkg::CORR_W;
  localparam int unsigned ProdW  = lfpd_pkg::PROD_W;
  localparam int unsigned ScaleW = lfpd_pkg::SCALE_W;

  // configuration registers
  logic [ThrBits-1:0]               left_thr_q, right_thr_q;
  logic [lfpd_pkg::GAIN_W-1:0]      prop_gain_q, deriv_gain_q;
  logic [lfpd_pkg::LOST_W-1:0]      lost_gain_q;
  logic [ScaleW-1:0]                scale_q;
  logic [lfpd_pkg::SPEED_W-1:0]     speed_q;

  // captured transaction
  logic                             follow_q;
  logic [SENSOR_BITS-1:0]           left_q, right_q;

  // state
  logic signed [ErrW-1:0]           last_err_q;
  logic signed [CorrW-1:0]          corr_q;

  // working registers
  logic signed [lfpd_pkg::PPROD_W-1:0] p_prod_q;
  logic signed [CorrW-1:0]          d_prod_q;
  logic                             neg_q;
  logic [ProdW-1:0]                 quo_q;
  logic [ScaleW-1:0]                rem_q;

  // output register
  logic                             out_valid_q, out_valid_d;
  logic [lfpd_pkg::SPEED_W-1:0]     speed_out_q;
  logic signed [lfpd_pkg::STEER_W-1:0] steer_out_q;
  logic signed [CorrW-1:0]          corr_out_q;

  // combinational
  logic                             left_on, right_on;
  logic signed [ErrW-1:0]           lost_gain_s;
  logic signed [ErrW-1:0]           err_d;
  logic signed [DiffW-1:0]          diff_d;
  logic signed [lfpd_pkg::PPROD_W-1:0] p_prod_d;
  logic signed [CorrW-1:0]          d_prod_d;
  logic signed [CorrW-1:0]          corr_d;
  logic [CorrW-1:0]                 corr_mag;
  logic [ProdW-1:0]                 prod_d;
  logic [ScaleW-1:0]                divisor;
  logic [ScaleW:0]                  trial;
  logic                             ge;
  logic [lfpd_pkg::STEER_W-2:0]     steer_mag;
  logic signed [lfpd_pkg::STEER_W-1:0] steer_d;

  // ---- configuration ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_thr_q   <= '0;
      right_thr_q  <= '0;
      prop_gain_q  <= '0;
      deriv_gain_q <= '0;
      lost_gain_q  <= lfpd_pkg::LOST_W'(1);
      scale_q      <= ScaleW'(1);
      speed_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lfpd_pkg::REG_LEFT_THR:    left_thr_q   <= cfg_wdata_i[ThrBits-1:0];
        lfpd_pkg::REG_RIGHT_THR:   right_thr_q  <= cfg_wdata_i[ThrBits-1:0];
        lfpd_pkg::REG_PROP_GAIN:   prop_gain_q  <= cfg_wdata_i[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_DERIV_GAIN:  deriv_gain_q <= cfg_wdata_i[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_LOST_GAIN:   lost_gain_q  <= cfg_wdata_i[lfpd_pkg::LOST_W-1:0];
        lfpd_pkg::REG_CORR_SCALE:  scale_q      <= cfg_wdata_i[ScaleW-1:0];
        lfpd_pkg::REG_DRIVE_SPEED: speed_q      <= cfg_wdata_i[lfpd_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- error decision ----
  assign left_on     = left_q  > SENSOR_BITS'(left_thr_q);
  assign right_on    = right_q > SENSOR_BITS'(right_thr_q);
  assign lost_gain_s = $signed({1'b0, lost_gain_q});

  // a last error of +-1 scaled by the lost-line gain is just a select
  always_comb begin
    priority if (left_on && right_on) err_d = '0;
    else if (left_on)                 err_d = -ErrW'(1);
    else if (right_on)                err_d = ErrW'(1);
    else if (last_err_q == ErrW'(1))  err_d = lost_gain_s;
    else if (last_err_q == -ErrW'(1)) err_d = -lost_gain_s;
    else                              err_d = last_err_q;
  end

  assign diff_d   = DiffW'(err_d) - DiffW'(last_err_q);
  assign p_prod_d = $signed({1'b0, prop_gain_q}) * err_d;
  assign d_prod_d = $signed({1'b0, deriv_gain_q}) * diff_d;
  assign corr_d   = CorrW'(p_prod_q) + d_prod_q;

  // ---- steer product and divider ----
  assign corr_mag = corr_q[CorrW-1] ? CorrW'(-corr_q) : CorrW'(corr_q);
  assign prod_d   = ProdW'(speed_q) * ProdW'(corr_mag);
  assign divisor  = (scale_q == '0) ? ScaleW'(1) : scale_q;
  assign trial    = {rem_q, quo_q[ProdW-1]};
  assign ge       = trial >= {1'b0, divisor};

  assign steer_mag = (|quo_q[ProdW-1:lfpd_pkg::STEER_W-1]) ? lfpd_pkg::STEER_MAG_MAX
                                                          : quo_q[lfpd_pkg::STEER_W-2:0];
  assign steer_d   = neg_q ? -$signed({1'b0, steer_mag}) : $signed({1'b0, steer_mag});

  // ---- state registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      corr_q     <= '0;
    end else begin
      if (cmd_i.err) last_err_q <= err_d;
      if (cmd_i.sum) corr_q     <= corr_d;
    end
  end

  // ---- working registers ----
  // the partial remainder stays below the divisor, so it fits ScaleW bits
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      follow_q <= follow_mode_i;
      left_q   <= left_level_i;
      right_q  <= right_level_i;
    end
    if (cmd_i.err) begin
      p_prod_q <= p_prod_d;
      d_prod_q <= d_prod_d;
    end
    if (cmd_i.mul) begin
      neg_q <= corr_q[CorrW-1];
      quo_q <= prod_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[ProdW-2:0], ge};
      rem_q <= ge ? ScaleW'(trial - {1'b0, divisor}) : trial[ScaleW-1:0];
    end
  end

  // ---- output register ----
  assign out_valid_d = cmd_i.finish || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      speed_out_q <= follow_q ? speed_q : '0;
      steer_out_q <= follow_q ? steer_d : '0;
      corr_out_q  <= corr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign speed_out_o      = speed_out_q;
  assign steer_out_o      = steer_out_q;
  assign correction_out_o = corr_out_q;

  assign status_o.in_follow = follow_mode_i;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

FILE: rtl/line_follow_pd_steer_top.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steer_top
// PD line-follower steering controller: two reflectance samples in, drive
// speed, saturated steer and PD correction out.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   input    | in        | in_valid_i/in_stall_o| follow_mode, left/right_level
//   output   | out       | out_valid_o/out_stall_i | speed_out, steer_out, correction_out
//   config   | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_wdata_i
//
// A follow transaction runs from acceptance to result through error and
// products, sum, multiply, 29 steps of the serial divider and hand-over; a
// stop transaction goes straight from acceptance to hand-over.
// One transaction is in flight at a time; the next is accepted as soon as the
// result sits in the output register, even while it is stalled there.
// Reset clears the stored error and correction and loads register defaults.
// ----------------------------------------------------------------------------
module line_follow_pd_steer_top #(
  parameter int unsigned SENSOR_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 follow_mode_i,
  input  logic [SENSOR_BITS-1:0]               left_level_i,
  input  logic [SENSOR_BITS-1:0]               right_level_i,
  // output
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lfpd_pkg::SPEED_W-1:0]         speed_out_o,
  output logic signed [lfpd_pkg::STEER_W-1:0]  steer_out_o,
  output logic signed [lfpd_pkg::CORR_W-1:0]   correction_out_o
);

  lfpd_pkg::lfpd_cmd_t    cmd;
  lfpd_pkg::lfpd_status_t status;

  assign cfg_ready_o = 1'b1;

  lfpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfpd_dp #(
    .SENSOR_BITS (SENSOR_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .follow_mode_i    (follow_mode_i),
    .left_level_i     (left_level_i),
    .right_level_i    (right_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .speed_out_o      (speed_out_o),
    .steer_out_o      (steer_out_o),
    .correction_out_o (correction_out_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

FILE: verif/line_follow_pd_steer_top_test.sv
// ----------------------------------------------------------------------------
// line_follow_pd_steer_top_test
// Self-checking testbench for the PD line-follower steering block. Sensor
// transactions are queued by the stimulus process and handed to the block by
// a clocked driver. Each accepted transaction is run through a local PD
// steering calculation that keeps its own copy of the registers and of the
// stored error and correction. A clocked monitor checks every result
// transaction, field by field, against the oldest predicted result. Both
// sides idle in random bursts. Registers are reprogrammed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module line_follow_pd_steer_top_test;

  localparam int unsigned SENSOR_W  = 12;
  localparam int unsigned CYCLE_CAP = 500000;
  localparam longint      STEER_LIM = 127;
  localparam logic [lfpd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [SENSOR_W-1:0]            LEVEL_TOP  = '1;

  typedef struct packed {
    logic                follow;
    logic [SENSOR_W-1:0] left;
    logic [SENSOR_W-1:0] right;
  } sample_t;

  typedef struct packed {
    logic [lfpd_pkg::SPEED_W-1:0] speed;
    logic [lfpd_pkg::STEER_W-1:0] steer;
    logic [lfpd_pkg::CORR_W-1:0]  corr;
  } steer_res_t;

  logic                                 clk_i;
  logic                                 rst_ni        = 1'b0;
  logic                                 cfg_valid_i   = 1'b0;
  logic                                 cfg_ready_o;
  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [lfpd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i   = '0;
  logic                                 in_valid_i    = 1'b0;
  logic                                 in_stall_o;
  logic                                 follow_mode_i = 1'b0;
  logic [SENSOR_W-1:0]                  left_level_i  = '0;
  logic [SENSOR_W-1:0]                  right_level_i = '0;
  logic                                 out_valid_o;
  logic                                 out_stall_i   = 1'b0;
  logic [lfpd_pkg::SPEED_W-1:0]         speed_out_o;
  logic signed [lfpd_pkg::STEER_W-1:0]  steer_out_o;
  logic signed [lfpd_pkg::CORR_W-1:0]   correction_out_o;

  line_follow_pd_steer_top #(
    .SENSOR_BITS(SENSOR_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .follow_mode_i   (follow_mode_i),
    .left_level_i    (left_level_i),
    .right_level_i   (right_level_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .speed_out_o     (speed_out_o),
    .steer_out_o     (steer_out_o),
    .correction_out_o(correction_out_o)
  );

  // register shadow, reset values
  logic [lfpd_pkg::THR_W-1:0]   left_thr    = '0;
  logic [lfpd_pkg::THR_W-1:0]   right_thr   = '0;
  logic [lfpd_pkg::GAIN_W-1:0]  prop_gain   = '0;
  logic [lfpd_pkg::GAIN_W-1:0]  deriv_gain  = '0;
  logic [lfpd_pkg::LOST_W-1:0]  lost_gain   = 8'd1;
  logic [lfpd_pkg::SCALE_W-1:0] corr_scale  = 16'd1;
  logic [lfpd_pkg::SPEED_W-1:0] drive_speed = '0;

  logic signed [lfpd_pkg::ERR_W-1:0]  last_err  = '0;
  logic signed [lfpd_pkg::CORR_W-1:0] last_corr = '0;

  sample_t    sample_q[$];
  steer_res_t steer_due_q[$];
  int         mismatches  = 0;
  int         in_idle_pct = 0;
  int         stall_pct   = 0;
  int         cycles      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Expected result of one sensor transaction; a follow transaction advances the stored error.
  function automatic steer_res_t pd_steer_calc(logic follow, logic [SENSOR_W-1:0] left,
                                               logic [SENSOR_W-1:0] right);
    steer_res_t res;
    logic       left_on;
    logic       right_on;
    longint     prev;
    longint     err;
    longint     corr;
    longint     div;
    longint     quot;
    res  = '0;
    prev = longint'(last_err);
    if (!follow) begin
      res.corr = last_corr;
      return res;
    end
    left_on  = left > left_thr;
    right_on = right > right_thr;
    if (left_on && right_on)
      err = 0;
    else if (left_on)
      err = -1;
    else if (right_on)
      err = 1;
    else if (prev >= -1 && prev <= 1)
      err = prev * longint'(lost_gain);  // line lost: boost a small error
    else
      err = prev;
    corr = longint'(prop_gain) * err + longint'(deriv_gain) * (err - prev);
    div  = (corr_scale == 0) ? 1 : longint'(corr_scale);
    quot = longint'(drive_speed) * corr / div;
    if (quot > STEER_LIM)
      quot = STEER_LIM;
    else if (quot < -STEER_LIM)
      quot = -STEER_LIM;
    last_err  = err[lfpd_pkg::ERR_W-1:0];
    last_corr = corr[lfpd_pkg::CORR_W-1:0];
    res.speed = drive_speed;
    res.steer = quot[lfpd_pkg::STEER_W-1:0];
    res.corr  = corr[lfpd_pkg::CORR_W-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk_i) begin : drv
    sample_t nxt;
    int      gap_left;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        steer_due_q.push_back(pd_steer_calc(follow_mode_i, left_level_i, right_level_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
          gap_left = $urandom_range(0, 14);
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          in_valid_i    <= 1'b1;
          follow_mode_i <= nxt.follow;
          left_level_i  <= nxt.left;
          right_level_i <= nxt.right;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end else begin
      gap_left = 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin : mon
    steer_res_t want;
    int         stall_left;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (steer_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: speed %0d steer %0d corr %0d", $time,
                   speed_out_o, steer_out_o, correction_out_o);
        end else begin
          want = steer_due_q.pop_front();
          if (speed_out_o !== want.speed) begin
            mismatches++;
            $display("%0t: speed_out expected %0d, actual %0d", $time, want.speed,
                     speed_out_o);
          end
          if (steer_out_o !== want.steer) begin
            mismatches++;
            $display("%0t: steer_out expected %0d, actual %0d", $time,
                     $signed(want.steer), steer_out_o);
          end
          if (correction_out_o !== want.corr) begin
            mismatches++;
            $display("%0t: correction_out expected %0d, actual %0d", $time,
                     $signed(want.corr), correction_out_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      stall_left = 0;
    end
  end

  function automatic void add_sample(logic f, logic [SENSOR_W-1:0] l,
                                     logic [SENSOR_W-1:0] r);
    sample_q.push_back('{follow: f, left: l, right: r});
  endfunction

  // Called at a rising edge; leaves cfg_valid_i high for the caller to drop.
  task automatic write_reg(logic [lfpd_pkg::CFG_IDX_W-1:0]  idx,
                           logic [lfpd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      lfpd_pkg::REG_LEFT_THR:    left_thr    = data[lfpd_pkg::THR_W-1:0];
      lfpd_pkg::REG_RIGHT_THR:   right_thr   = data[lfpd_pkg::THR_W-1:0];
      lfpd_pkg::REG_PROP_GAIN:   prop_gain   = data[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::REG_DERIV_GAIN:  deriv_gain  = data[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::REG_LOST_GAIN:   lost_gain   = data[lfpd_pkg::LOST_W-1:0];
      lfpd_pkg::REG_CORR_SCALE:  corr_scale  = data[lfpd_pkg::SCALE_W-1:0];
      lfpd_pkg::REG_DRIVE_SPEED: drive_speed = data[lfpd_pkg::SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // Returns at a rising edge once every transaction is in and every result out.
  task automatic drain();
    do @(posedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || steer_due_q.size() != 0);
  endtask

  function automatic logic [lfpd_pkg::CFG_DATA_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return lfpd_pkg::CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [SENSOR_W-1:0] pick_level(logic [lfpd_pkg::THR_W-1:0] thr,
                                                     logic on);
    if (on && thr != LEVEL_TOP)
      return ($urandom_range(0, 3) == 0) ? thr + 1'b1
                                         : SENSOR_W'($urandom_range(LEVEL_TOP, thr + 1));
    else if (!on)
      return ($urandom_range(0, 3) == 0) ? thr : SENSOR_W'($urandom_range(thr, 0));
    return SENSOR_W'($urandom_range(LEVEL_TOP, 0));
  endfunction

  task automatic queue_random(int n);
    int   k;
    logic f;
    logic l_on;
    logic r_on;
    for (k = 0; k < n; k++) begin
      f    = ($urandom_range(0, 9) != 0);
      l_on = 1'($urandom_range(0, 1));
      r_on = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) == 0)
        add_sample(f, SENSOR_W'($urandom_range(LEVEL_TOP, 0)),
                   SENSOR_W'($urandom_range(LEVEL_TOP, 0)));
      else
        add_sample(f, pick_level(left_thr, l_on), pick_level(right_thr, r_on));
    end
  endtask

  initial begin : stim
    int ph;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: zero gains, lost-line gain of one
    add_sample(1'b0, 12'd7, 12'd9);
    add_sample(1'b1, 12'd1, 12'd0);
    add_sample(1'b1, 12'd0, 12'd0);
    drain();

    // full gains, top speed, unit scale; upper data bits must be dropped
    write_reg(lfpd_pkg::REG_LEFT_THR, 16'hF800);
    write_reg(lfpd_pkg::REG_RIGHT_THR, 16'h03E8);
    write_reg(lfpd_pkg::REG_PROP_GAIN, 16'hFFFF);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, 16'hFFFF);
    write_reg(lfpd_pkg::REG_LOST_GAIN, 16'hFFFF);
    write_reg(lfpd_pkg::REG_CORR_SCALE, 16'h0001);
    write_reg(lfpd_pkg::REG_DRIVE_SPEED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    add_sample(1'b0, LEVEL_TOP, LEVEL_TOP);
    add_sample(1'b1, LEVEL_TOP, LEVEL_TOP);
    add_sample(1'b1, 12'd2049, 12'd1000);
    add_sample(1'b1, 12'd2048, 12'd1001);
    add_sample(1'b1, 12'd0, 12'd0);      // line lost after a unit error
    add_sample(1'b1, 12'd0, 12'd0);      // large error held
    add_sample(1'b0, 12'd0, 12'd0);
    add_sample(1'b1, LEVEL_TOP, 12'd0);
    add_sample(1'b1, 12'd2048, 12'd1000);
    add_sample(1'b1, 12'hAAA, 12'h555);
    add_sample(1'b1, 12'h555, 12'hAAA);
    drain();

    // zero scale, zero lost-line gain, left never sees the line
    write_reg(lfpd_pkg::REG_LEFT_THR, 16'hFFFF);
    write_reg(lfpd_pkg::REG_RIGHT_THR, 16'h0000);
    write_reg(lfpd_pkg::REG_PROP_GAIN, 16'hFC00);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, 16'h0155);
    write_reg(lfpd_pkg::REG_LOST_GAIN, 16'h0000);
    write_reg(lfpd_pkg::REG_CORR_SCALE, 16'h0000);
    write_reg(lfpd_pkg::REG_DRIVE_SPEED, 16'h0080);
    write_reg(REG_UNUSED, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    add_sample(1'b1, LEVEL_TOP, LEVEL_TOP);
    add_sample(1'b1, LEVEL_TOP, 12'd0);
    add_sample(1'b1, 12'd0, 12'd1);
    add_sample(1'b0, LEVEL_TOP, LEVEL_TOP);
    add_sample(1'b1, 12'd0, 12'd0);

    for (ph = 0; ph < 8; ph++) begin
      drain();
      write_reg(lfpd_pkg::REG_LEFT_THR, pick_word());
      write_reg(lfpd_pkg::REG_RIGHT_THR, pick_word());
      write_reg(lfpd_pkg::REG_PROP_GAIN, pick_word());
      write_reg(lfpd_pkg::REG_DERIV_GAIN, pick_word());
      write_reg(lfpd_pkg::REG_LOST_GAIN, pick_word());
      write_reg(lfpd_pkg::REG_CORR_SCALE, pick_word());
      write_reg(lfpd_pkg::REG_DRIVE_SPEED, pick_word());
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_UNUSED, pick_word());
      cfg_valid_i <= 1'b0;
      // last phase runs flat out on both sides
      in_idle_pct = (ph == 7) ? 0 : 10 * $urandom_range(0, 4);
      stall_pct   = (ph == 7) ? 0 : 10 * $urandom_range(0, 4);
      queue_random(75);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && steer_due_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
